FILE: hw/rtl/rstr_pkg.sv
`timescale 1ns / 1ps

package rstr_pkg;

  localparam int HASH_W = 8;
  localparam int LEN_W  = 16;
  localparam int CP_W   = 21;

  localparam logic [HASH_W-1:0] MAX_HASHES       = 8'd255;
  localparam logic [LEN_W-1:0]  MAX_TOKEN_LENGTH = 16'hFFFF;
  localparam logic [HASH_W-1:0] QUOTES_NEEDED    = 8'd3;

  localparam logic [CP_W-1:0] CH_R     = 21'h72;
  localparam logic [CP_W-1:0] CH_HASH  = 21'h23;
  localparam logic [CP_W-1:0] CH_QUOTE = 21'h22;
  localparam logic [CP_W-1:0] CH_SPACE = 21'h20;
  localparam logic [CP_W-1:0] CH_TAB   = 21'h09;
  localparam logic [CP_W-1:0] CH_CR    = 21'h0D;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WS    = 3'd1,
    PH_HASH  = 3'd2,
    PH_OPENQ = 3'd3,
    PH_BODY  = 3'd4,
    PH_QRUN  = 3'd5,
    PH_TRAIL = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_CONT = 2'd0,
    ST_ACC  = 2'd1,
    ST_REJ  = 2'd2,
    ST_IDLE = 2'd3
  } status_t;

  typedef struct packed {
    phase_t              phase;
    logic [HASH_W-1:0]   open_hash_count;
    logic [HASH_W-1:0]   run_count;
    logic [LEN_W-1:0]    length_count;
  } rstr_state_t;

  typedef struct packed {
    status_t             status;
    logic [LEN_W-1:0]    token_length;
    logic                length_saturated;
  } rstr_result_t;

  localparam rstr_state_t STATE_CLEAR = '{
    phase:           PH_IDLE,
    open_hash_count: '0,
    run_count:       '0,
    length_count:    '0
  };

endpackage

FILE: hw/rtl/rstr_step.sv
`timescale 1ns / 1ps

module rstr_step
  import rstr_pkg::*;
(
  input  rstr_state_t        cur_state,
  input  logic               start_req,
  input  logic               raw_allowed,
  input  logic [CP_W-1:0]    code_point,
  input  logic               at_end,
  output rstr_state_t        state_next,
  output rstr_result_t       result
);

  logic              is_q;
  logic              is_h;
  logic              is_r;
  logic              is_ws;
  logic [LEN_W-1:0]  len_bump;
  logic [HASH_W-1:0] run_inc;
  logic [HASH_W-1:0] trail_run;
  logic              take_trail;
  logic              take_body;
  rstr_state_t       base;
  rstr_state_t       nxt;
  status_t           st;

  assign is_q  = !at_end && (code_point == CH_QUOTE);
  assign is_h  = !at_end && (code_point == CH_HASH);
  assign is_r  = !at_end && (code_point == CH_R);
  assign is_ws = !at_end && ((code_point == CH_SPACE) ||
                 ((code_point >= CH_TAB) && (code_point <= CH_CR)));

  always_comb begin
    base       = cur_state;
    st         = ST_IDLE;
    take_trail = 1'b0;
    take_body  = 1'b0;
    trail_run  = cur_state.run_count;

    // a start mark drops any open scan
    if (start_req) begin
      base = STATE_CLEAR;
      if (raw_allowed) begin
        base.phase = PH_WS;
      end else begin
        st = ST_REJ;
      end
    end

    len_bump = (base.length_count == MAX_TOKEN_LENGTH) ? base.length_count
                                                       : base.length_count + 16'd1;
    nxt = base;

    case (base.phase)
      PH_IDLE: begin
        nxt = base;
      end
      PH_WS: begin
        if (is_ws) begin
          st = ST_CONT;
        end else if (is_r) begin
          nxt.length_count = len_bump;
          nxt.phase        = PH_HASH;
          st               = ST_CONT;
        end else begin
          st = ST_REJ;
        end
      end
      PH_HASH: begin
        if (is_h) begin
          if (base.open_hash_count >= MAX_HASHES) begin
            st = ST_REJ;
          end else begin
            nxt.open_hash_count = base.open_hash_count + 8'd1;
            nxt.length_count    = len_bump;
            st                  = ST_CONT;
          end
        end else if (is_q) begin
          nxt.length_count = len_bump;
          nxt.run_count    = 8'd1;
          nxt.phase        = PH_OPENQ;
          st               = ST_CONT;
        end else begin
          st = ST_REJ;
        end
      end
      PH_OPENQ: begin
        if (is_q) begin
          nxt.length_count = len_bump;
          if (base.run_count + 8'd1 >= QUOTES_NEEDED) begin
            nxt.run_count = '0;
            nxt.phase     = PH_BODY;
          end else begin
            nxt.run_count = base.run_count + 8'd1;
          end
          st = ST_CONT;
        end else begin
          st = ST_REJ;
        end
      end
      PH_BODY: begin
        take_body = 1'b1;
      end
      PH_QRUN: begin
        if (is_q) begin
          nxt.length_count = len_bump;
          if (base.run_count < QUOTES_NEEDED) begin
            nxt.run_count = base.run_count + 8'd1;
          end
          st = ST_CONT;
        end else if (base.run_count < QUOTES_NEEDED) begin
          take_body = 1'b1;
        end else if (base.open_hash_count == '0) begin
          st = ST_ACC;
        end else begin
          // long enough quote run: a hash here starts the trailing hashes
          trail_run  = '0;
          take_trail = 1'b1;
        end
      end
      PH_TRAIL: begin
        take_trail = 1'b1;
      end
      default: begin
        st = ST_REJ;
      end
    endcase

    run_inc = trail_run + 8'd1;
    if (take_trail) begin
      if (is_h) begin
        nxt.length_count = len_bump;
        nxt.run_count    = run_inc;
        if (run_inc >= base.open_hash_count) begin
          st = ST_ACC;
        end else begin
          nxt.phase = PH_TRAIL;
          st        = ST_CONT;
        end
      end else begin
        // run did not close the token, character is body content again
        nxt.run_count = trail_run;
        take_body     = 1'b1;
      end
    end

    if (take_body) begin
      nxt.phase = PH_BODY;
      if (at_end) begin
        st = ST_REJ;
      end else begin
        nxt.length_count = len_bump;
        st               = ST_CONT;
        if (is_q) begin
          nxt.run_count = 8'd1;
          nxt.phase     = PH_QRUN;
        end
      end
    end

    result.status           = st;
    result.token_length     = '0;
    result.length_saturated = 1'b0;
    state_next              = nxt;
    if (st == ST_ACC) begin
      result.token_length     = nxt.length_count;
      result.length_saturated = (nxt.length_count == MAX_TOKEN_LENGTH);
      state_next              = STATE_CLEAR;
    end else if (st == ST_REJ) begin
      state_next = STATE_CLEAR;
    end
  end

endmodule

FILE: hw/rtl/raw_string_token_recognizer_top.sv
`timescale 1ns / 1ps

// raw string token recognizer: r, N hashes, three quotes, body, closing
// quote run of three or more, then N hashes
// input channel (in_valid/in_ready) carries one lookahead character per
// transfer with start_req, raw_allowed, code_point and at_end
// output channel (out_valid/out_ready) returns exactly one result per input
// transfer: status, token_length, length_saturated
// a result comes from the input register through the scan step into the
// result register; throughput: one character per cycle unless the receiver
// stalls; the scan state is a single register updated by one step of short
// compare logic, so nothing iterates
// when the receiver stalls, the result register holds, the input register
// fills behind it and in_ready drops; transfers resume without loss
// reset (rst, synchronous) empties both registers and returns the scanner
// to idle with all counters cleared

module raw_string_token_recognizer_top
  import rstr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              start_req,
  input  logic              raw_allowed,
  input  logic [CP_W-1:0]   code_point,
  input  logic              at_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [LEN_W-1:0]  token_length,
  output logic              length_saturated
);

  logic              s1_valid;
  logic              s1_start;
  logic              s1_allowed;
  logic [CP_W-1:0]   s1_cp;
  logic              s1_end;
  logic              s1_fire;
  rstr_state_t       scan;
  rstr_state_t       scan_next;
  rstr_result_t      step_result;
  rstr_result_t      res;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start   <= start_req;
      s1_allowed <= raw_allowed;
      s1_cp      <= code_point;
      s1_end     <= at_end;
    end
  end

  rstr_step u_step (
    .cur_state   (scan),
    .start_req   (s1_start),
    .raw_allowed (s1_allowed),
    .code_point  (s1_cp),
    .at_end      (s1_end),
    .state_next  (scan_next),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= STATE_CLEAR;
    end else if (s1_fire) begin
      scan <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= step_result;
    end
  end

  assign status           = res.status;
  assign token_length     = res.token_length;
  assign length_saturated = res.length_saturated;

endmodule

FILE: hw/rtl/rstr_checker.sv
`timescale 1ns / 1ps

module rstr_checker
  import rstr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        status,
  input logic [LEN_W-1:0]  token_length,
  input logic              length_saturated
);

  // shortest token r followed by six quotes is seven characters
  localparam logic [LEN_W-1:0] MIN_TOKEN = 16'd7;

  a_len_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_ACC) |-> (token_length == '0) && !length_saturated)
    else $error("length reported without accept");

  a_sat_means_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_saturated |-> (token_length == MAX_TOKEN_LENGTH))
    else $error("saturation flag without full length");

  a_min_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ACC) |-> (token_length >= MIN_TOKEN))
    else $error("accepted token shorter than minimum");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(token_length))
    else $error("stalled result changed");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind raw_string_token_recognizer_top rstr_checker u_rstr_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .status           (status),
  .token_length     (token_length),
  .length_saturated (length_saturated)
);
